// ----- rtl/shc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shc_pkg
// Word types and codes shared by the systematic Hamming SEC/SECDED codec.
// ----------------------------------------------------------------------------
package shc_pkg;

	// field widths of the command and response words
	localparam int DATA_W   = 32;
	localparam int CODE_W   = 39;
	localparam int SYND_W   = 7;
	localparam int STATUS_W = 2;

	// operation requested by a command word
	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} opcode_t;

	// decode outcome
	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_CORRECTED     = 2'd1,
		ST_UNCORRECTABLE = 2'd2
	} status_t;

	// command word
	typedef struct packed {
		opcode_t           opcode;
		logic [DATA_W-1:0] data_word;
		logic [CODE_W-1:0] codeword_in;
	} cmd_t;

	// response word
	typedef struct packed {
		logic [CODE_W-1:0] codeword_out;
		logic [DATA_W-1:0] data_out;
		logic [SYND_W-1:0] syndrome;
		status_t           status;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/systematic_hamming_secded_codec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// systematic_hamming_secded_codec
// Systematic Hamming encoder/decoder, single error correct with optional
// double error detect (extended_mode) through an overall parity bit.
// ----------------------------------------------------------------------------
// A command word is taken on every cycle with start high; busy is always low.
// Each word gives one response word, shown for one cycle with done high, from the
// result register; the receiver cannot stall it, so it must take every response.
// The path is an input register, one level of XOR trees and column compares,
// and a result register, so the sustained rate is one word per clock.
// cfg_we writes the extended_mode bit; change it only while no word is in flight.
module systematic_hamming_secded_codec #(
	parameter int DATA_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire shc_pkg::cmd_t cmd,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	output logic               done,
	output shc_pkg::rsp_t      rsp
);

	// number of check bits for k data bits
	function automatic int check_len(input int k);
		int r;
		r = 1;
		if (k == 1) begin
			return 2;
		end
		while ((1 << r) < r + k + 1) begin
			r++;
		end
		return r;
	endfunction

	// data width held to the supported range
	localparam int K = (DATA_BITS < 1) ? 1 : (DATA_BITS > 57) ? 57 : DATA_BITS;
	localparam int R = check_len(K);
	localparam int W = K + R + 1;

	// column labels: integers from 3 upward skipping powers of two
	function automatic logic [K-1:0][R-1:0] make_labels();
		int                     v;
		logic [K-1:0][R-1:0]    lab;
		v   = 3;
		lab = '0;
		for (int j = 0; j < K; j++) begin
			if ((v & (v - 1)) == 0) begin
				v++;
			end
			lab[j] = v[R-1:0];
			v++;
		end
		return lab;
	endfunction

	localparam logic [K-1:0][R-1:0] LABELS = make_labels();

	// mode register
	logic ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
		end else if (cfg_we) begin
			ext_q <= cfg_wdata;
		end
	end

	// input register
	shc_pkg::cmd_t cmd_s1;
	logic          vld_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
		end
	end

	// resize incoming fields to the internal code length
	logic [K+shc_pkg::DATA_W-1:0] data_ext;
	logic [W+shc_pkg::CODE_W-1:0] cwin_ext;
	logic [K-1:0]                 enc_d;
	logic [W-1:0]                 y_raw;
	logic [W-1:0]                 y;

	assign data_ext = {{K{1'b0}}, cmd_s1.data_word};
	assign cwin_ext = {{W{1'b0}}, cmd_s1.codeword_in};
	assign enc_d    = data_ext[K-1:0];
	assign y_raw    = cwin_ext[W-1:0];

	// the parity position only exists in extended mode
	always_comb begin
		y        = y_raw;
		y[K+R]   = y_raw[K+R] & ext_q;
	end

	// check bits of the word being encoded and of the received data
	logic [K-1:0] dec_d;
	logic [R-1:0] enc_c;
	logic [R-1:0] dec_c;

	assign dec_d = y[K-1:0];

	always_comb begin
		enc_c = '0;
		dec_c = '0;
		for (int j = 0; j < K; j++) begin
			enc_c = enc_c ^ (LABELS[j] & {R{enc_d[j]}});
			dec_c = dec_c ^ (LABELS[j] & {R{dec_d[j]}});
		end
	end

	// encoded word
	logic [W-1:0] enc_cw;

	assign enc_cw = {ext_q & ((^enc_d) ^ (^enc_c)), enc_c, enc_d};

	// syndrome, with the overall parity syndrome on top
	logic [R:0] syn;

	assign syn = {ext_q & (^y), y[K+R-1:K] ^ dec_c};

	// match the syndrome against every parity-check column
	logic [W-1:0] flip;

	always_comb begin
		for (int p = 0; p < K; p++) begin
			flip[p] = (syn == {ext_q, LABELS[p]});
		end
		for (int i = 0; i < R; i++) begin
			flip[K+i] = (syn == {ext_q, R'(1) << i});
		end
		flip[K+R] = ext_q & (syn == {1'b1, {R{1'b0}}});
	end

	logic [W-1:0] dec_cw;
	logic         syn_nz;

	assign syn_nz = |syn;
	assign dec_cw = y ^ (flip & {W{syn_nz}});

	// select the response fields
	logic [W-1:0]                     res_cw;
	logic [W+shc_pkg::CODE_W-1:0]     res_cw_ext;
	logic [K+shc_pkg::DATA_W-1:0]     res_d_ext;
	logic [R+shc_pkg::SYND_W:0]       res_syn_ext;
	shc_pkg::status_t                 res_st;
	shc_pkg::rsp_t                    rsp_nxt;

	always_comb begin
		if (cmd_s1.opcode == shc_pkg::OP_DECODE) begin
			res_cw = dec_cw;
			if (!syn_nz) begin
				res_st = shc_pkg::ST_OK;
			end else if (|flip) begin
				res_st = shc_pkg::ST_CORRECTED;
			end else begin
				res_st = shc_pkg::ST_UNCORRECTABLE;
			end
			res_syn_ext = {{shc_pkg::SYND_W{1'b0}}, syn};
		end else begin
			res_cw      = enc_cw;
			res_st      = shc_pkg::ST_OK;
			res_syn_ext = '0;
		end
	end

	assign res_cw_ext = {{shc_pkg::CODE_W{1'b0}}, res_cw};
	assign res_d_ext  = {{shc_pkg::DATA_W{1'b0}}, res_cw[K-1:0]};

	always_comb begin
		rsp_nxt.codeword_out = res_cw_ext[shc_pkg::CODE_W-1:0];
		rsp_nxt.data_out     = res_d_ext[shc_pkg::DATA_W-1:0];
		rsp_nxt.syndrome     = res_syn_ext[shc_pkg::SYND_W-1:0];
		rsp_nxt.status       = res_st;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp <= rsp_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- dv/hamming_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_checker
// Watches the command, configuration and response channels of the Hamming
// codec. Each accepted command word gets its expected response from a local
// SEC/SECDED model. Every response is checked field by field against the
// oldest expected one.
// ----------------------------------------------------------------------------
module hamming_checker #(
	parameter int DATA_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  shc_pkg::cmd_t  cmd,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           done,
	input  shc_pkg::rsp_t  rsp,
	output int             fail_count,
	output int             words_due_count
);

	// data width clamped into the supported range
	function automatic int data_len();
		int k;
		k = DATA_BITS;
		if (k < 1) k = 1;
		if (k > 57) k = 57;
		return k;
	endfunction

	// least check count covering every single-bit position
	function automatic int check_len(int k);
		int r;
		r = 1;
		if (k == 1) return 2;
		while ((1 << r) < r + k + 1) r++;
		return r;
	endfunction

	localparam int K = data_len();
	localparam int R = check_len(K);

	// column label of data bit j: j-th integer from 3 up that is not a power of two
	function automatic logic [63:0] column_label(int j);
		logic [63:0] v;
		logic [63:0] lab;
		v = 64'd3;
		lab = '0;
		for (int i = 0; i <= j; i++) begin
			if ((v & (v - 64'd1)) == 64'd0) v++;
			lab = v;
			v++;
		end
		return lab;
	endfunction

	// check bits: xor of the labels of all set data bits
	function automatic logic [63:0] check_bits(logic [63:0] d);
		logic [63:0] c;
		c = '0;
		for (int j = 0; j < K; j++)
			if (d[j]) c ^= column_label(j);
		return c;
	endfunction

	// expected response word for one command word
	function automatic shc_pkg::rsp_t codec_predict(shc_pkg::cmd_t c, logic ext);
		shc_pkg::rsp_t    w;
		logic [63:0]      kmask;
		logic [63:0]      rmask;
		logic [63:0]      nmask;
		logic [63:0]      pbit;
		logic [63:0]      d;
		logic [63:0]      chk;
		logic [63:0]      y;
		logic [63:0]      syn;
		logic [63:0]      col;
		shc_pkg::status_t st;
		int               n;
		w = '0;
		n = K + R + (ext ? 1 : 0);
		kmask = (64'd1 << K) - 64'd1;
		rmask = (64'd1 << R) - 64'd1;
		nmask = (64'd1 << n) - 64'd1;
		pbit = ext ? (64'd1 << R) : 64'd0;
		syn = '0;
		st = shc_pkg::ST_OK;
		if (c.opcode == shc_pkg::OP_ENCODE) begin
			d = 64'(c.data_word) & kmask;
			chk = check_bits(d);
			y = d | (chk << K);
			if (ext) y |= 64'(^d ^ ^chk) << (K + R);
		end else begin
			y = 64'(c.codeword_in) & nmask;
			d = y & kmask;
			chk = (y >> K) & rmask;
			syn = chk ^ check_bits(d);
			if (ext) syn |= 64'(^y) << R;
			// look for the one column that matches the syndrome
			if (syn != 64'd0) begin
				st = shc_pkg::ST_UNCORRECTABLE;
				for (int b = 0; b < n; b++) begin
					if (b < K) col = column_label(b) | pbit;
					else if (b < K + R) col = (64'd1 << (b - K)) | pbit;
					else col = 64'd1 << R;
					if (st == shc_pkg::ST_UNCORRECTABLE && col == syn) begin
						y ^= 64'd1 << b;
						st = shc_pkg::ST_CORRECTED;
					end
				end
			end
		end
		w.codeword_out = y[shc_pkg::CODE_W-1:0];
		w.data_out = y[shc_pkg::DATA_W-1:0] & kmask[shc_pkg::DATA_W-1:0];
		w.syndrome = syn[shc_pkg::SYND_W-1:0];
		w.status = st;
		return w;
	endfunction

	shc_pkg::rsp_t words_due[$];
	logic ext_mode;
	int   n_bad = 0;
	int   n_due = 0;

	assign fail_count = n_bad;
	assign words_due_count = n_due;

	// predict on accept, compare on done
	always @(posedge clk or negedge arst_n) begin
		shc_pkg::rsp_t exp_w;
		if (!arst_n) begin
			ext_mode = 1'b0;
			words_due.delete();
			n_due = 0;
		end else begin
			if (done) begin
				if (words_due.size() == 0) begin
					n_bad++;
					$display("%0t: response word with none expected, actual %h", $time, rsp);
				end else begin
					exp_w = words_due.pop_front();
					if (rsp.codeword_out !== exp_w.codeword_out) begin
						n_bad++;
						$display("%0t: codeword_out expected %h actual %h",
							$time, exp_w.codeword_out, rsp.codeword_out);
					end
					if (rsp.data_out !== exp_w.data_out) begin
						n_bad++;
						$display("%0t: data_out expected %h actual %h",
							$time, exp_w.data_out, rsp.data_out);
					end
					if (rsp.syndrome !== exp_w.syndrome) begin
						n_bad++;
						$display("%0t: syndrome expected %h actual %h",
							$time, exp_w.syndrome, rsp.syndrome);
					end
					if (rsp.status !== exp_w.status) begin
						n_bad++;
						$display("%0t: status expected %0d actual %0d",
							$time, exp_w.status, rsp.status);
					end
				end
			end
			if (start && !busy) words_due.push_back(codec_predict(cmd, ext_mode));
			// a write takes effect for words accepted after this edge
			if (cfg_we) ext_mode = cfg_wdata;
			n_due = words_due.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Hamming SEC/SECDED codec: directed corner words, then
// random encodes and decodes in bursts, across both parity modes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT = 200000;
	localparam int PARITY_BIT = shc_pkg::CODE_W - 1;
	// syndromes above the last data label (38) match no column
	localparam logic [63:0] FREE_SYND = 64'd39;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	shc_pkg::cmd_t  cmd = '0;
	logic           cfg_we = 1'b0;
	logic           cfg_wdata = 1'b0;
	logic           done;
	shc_pkg::rsp_t  rsp;
	int             fail_count;
	int             words_due_count;

	logic [shc_pkg::CODE_W-1:0] good_words[$];
	int cycles = 0;
	int n_enc = 0;
	int n_dec = 0;
	int n_noise = 0;
	int n_mode_writes = 0;

	systematic_hamming_secded_codec #(.DATA_BITS(shc_pkg::DATA_W)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp)
	);

	hamming_checker #(.DATA_BITS(shc_pkg::DATA_W)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp),
		.fail_count(fail_count), .words_due_count(words_due_count)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// keep recent valid codewords to corrupt for decode words
	always @(posedge clk) begin
		if (arst_n && done && rsp.status != shc_pkg::ST_UNCORRECTABLE) begin
			good_words.push_back(rsp.codeword_out);
			if (good_words.size() > 32) void'(good_words.pop_front());
		end
	end

	function automatic logic [shc_pkg::CODE_W-1:0] rand_code();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[shc_pkg::CODE_W-1:0];
	endfunction

	// hand one command word over, hold until accepted
	task automatic send(shc_pkg::opcode_t op, logic [shc_pkg::DATA_W-1:0] d,
			logic [shc_pkg::CODE_W-1:0] cw);
		start <= 1'b1;
		cmd <= '{opcode: op, data_word: d, codeword_in: cw};
		do @(posedge clk); while (busy);
		if (op == shc_pkg::OP_ENCODE) n_enc++;
		else n_dec++;
	endtask

	task automatic send_enc(logic [shc_pkg::DATA_W-1:0] d);
		send(shc_pkg::OP_ENCODE, d, rand_code());
	endtask

	task automatic send_dec(logic [shc_pkg::CODE_W-1:0] cw);
		send(shc_pkg::OP_DECODE, $urandom, cw);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending until every expected word is back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (words_due_count != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_mode(logic m);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		good_words.delete();
		n_mode_writes++;
	endtask

	// corner words around the all-zero codeword, valid in both modes
	task automatic run_directed(logic ext);
		send_enc('0);
		send_enc('1);
		send_enc(32'h1);
		send_enc(32'h8000_0000);
		send_enc(32'hA5A5_A5A5);
		send_dec('0);
		send_dec(39'd1);
		send_dec(39'd1 << (shc_pkg::DATA_W - 1));
		send_dec(39'd1 << shc_pkg::DATA_W);
		send_dec('1);
		if (!ext) begin
			// unmatched syndrome, then a set bit above the codeword
			send_dec(39'(FREE_SYND << shc_pkg::DATA_W));
			send_dec(39'd1 << PARITY_BIT);
		end else begin
			// parity bit alone, then two double errors
			send_dec(39'd1 << PARITY_BIT);
			send_dec(39'd3);
			send_dec((39'd1 << 5) | (39'd1 << PARITY_BIT));
		end
		pause(1);
	endtask

	// random word: encodes, corrupted valid codewords, and noise
	task automatic send_random();
		int pick;
		int flips;
		logic [shc_pkg::CODE_W-1:0] cw;
		logic [shc_pkg::DATA_W-1:0] d;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			case ($urandom_range(0, 9))
				0: d = 32'd1 << $urandom_range(0, shc_pkg::DATA_W - 1);
				1: d = ~(32'd1 << $urandom_range(0, shc_pkg::DATA_W - 1));
				default: d = $urandom;
			endcase
			send_enc(d);
		end else if (pick < 90 && good_words.size() != 0) begin
			cw = good_words[$urandom_range(0, good_words.size() - 1)];
			pick = $urandom_range(0, 99);
			flips = (pick < 20) ? 0 : (pick < 60) ? 1 : (pick < 85) ? 2 : 3;
			repeat (flips) cw[$urandom_range(0, shc_pkg::CODE_W - 1)] ^= 1'b1;
			send_dec(cw);
		end else begin
			n_noise++;
			send_dec(rand_code());
		end
	endtask

	// bursts of back-to-back words with random gaps
	task automatic run_random(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_random();
				sent++;
			end
			pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
		end
	endtask

	initial begin
		int w;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(1'b0);
		run_directed(1'b0);
		run_random(140);

		set_mode(1'b1);
		run_directed(1'b1);
		run_random(70);
		drain();
		run_random(70);

		set_mode(1'b0);
		run_random(120);

		set_mode(1'b1);
		run_random(120);

		// let the last words come back
		start <= 1'b0;
		w = 0;
		@(negedge clk);
		while (words_due_count != 0 && w < 1000) begin
			@(negedge clk);
			w++;
		end
		repeat (8) @(posedge clk);

		$display("covered %0d encode and %0d decode words (%0d noise)",
			n_enc, n_dec, n_noise);
		$display("over %0d mode writes in SEC and SECDED mode", n_mode_writes);
		if (fail_count == 0 && words_due_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
